@@ hdl/dls3d_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// DDA line stepper package
// Shared types, codes and fixed constants of the 3D line stepper.
// ----------------------------------------------------------------------------
package dls3d_pkg;

    localparam int STEPS_W = 10;
    localparam int INT_W   = 12;
    localparam int RND_W   = 13;

    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    localparam logic [1:0] REG_X_LIMIT = 2'd0;
    localparam logic [1:0] REG_Y_LIMIT = 2'd1;
    localparam logic [1:0] REG_Z_LIMIT = 2'd2;

    localparam logic [10:0] X_LIMIT_RST = 11'd960;
    localparam logic [10:0] Y_LIMIT_RST = 11'd960;
    localparam logic [7:0]  Z_LIMIT_RST = 8'd96;

    localparam logic [7:0] CELL_Z_HALF = 8'd12;

    typedef struct packed {
        logic latch;
        logic setup;
        logic div_run;
        logic div_first;
        logic store_step;
        logic check;
        logic update;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic is_tick;
        logic start_ok;
    } sts_t;

endpackage
`default_nettype wire

@@ hdl/dda_line_stepper_3d.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// 3D DDA line stepper
// Projectile line stepper: start beats set up position and per-tick steps,
// tick beats test bounds and advance; every beat returns one result.
//
//   Channel  Direction  Handshake           Payload
//   in       input      in_valid/in_stall   func, from_x/y/z, to_x/y/z
//   out      output     out_valid/out_stall pos_x/y/z, moving, shot_taken
//   cfg      input      APB write/read      x_limit, y_limit, z_limit
//
// An accepted start passes through setup, the three bit-serial divider lanes,
// the step store and the result state before its result is loaded.
// A tick passes through setup, bounds test and update; an ignored start goes from setup to the result state.
// Reset clears the limits to their defaults, the position, steps and flight.
// The next beat is taken while a result still waits on a stalled output.
// ----------------------------------------------------------------------------
module dda_line_stepper_3d
    import dls3d_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire logic           func,
    input  wire logic [5:0]     from_x,
    input  wire logic [5:0]     from_y,
    input  wire logic [2:0]     from_z,
    input  wire logic [5:0]     to_x,
    input  wire logic [5:0]     to_y,
    input  wire logic [2:0]     to_z,
    output logic                out_valid,
    input  wire logic           out_stall,
    output logic signed [11:0]  pos_x,
    output logic signed [11:0]  pos_y,
    output logic signed [8:0]   pos_z,
    output logic                moving,
    output logic                shot_taken,
    input  wire logic           psel,
    input  wire logic           penable,
    input  wire logic           pwrite,
    input  wire logic [3:0]     paddr,
    input  wire logic [31:0]    pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    cmd_t           cmd;
    sts_t           sts;
    logic [10:0]    x_limit_reg;
    logic [10:0]    y_limit_reg;
    logic [7:0]     z_limit_reg;
    logic           wr_en;
    logic [1:0]     reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_limit_reg <= X_LIMIT_RST;
            y_limit_reg <= Y_LIMIT_RST;
            z_limit_reg <= Z_LIMIT_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_X_LIMIT: x_limit_reg <= pwdata[10:0];
                REG_Y_LIMIT: y_limit_reg <= pwdata[10:0];
                REG_Z_LIMIT: z_limit_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_X_LIMIT: prdata = {21'd0, x_limit_reg};
            REG_Y_LIMIT: prdata = {21'd0, y_limit_reg};
            REG_Z_LIMIT: prdata = {24'd0, z_limit_reg};
            default:     prdata = '0;
        endcase
    end

    dls3d_ctrl #(.FRAC_BITS(FRAC_BITS)) u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .sts(sts),
        .cmd(cmd)
    );

    dls3d_datapath #(.FRAC_BITS(FRAC_BITS)) u_datapath (
        .clk(clk),
        .rst_n(rst_n),
        .cmd(cmd),
        .sts(sts),
        .func(func),
        .from_x(from_x),
        .from_y(from_y),
        .from_z(from_z),
        .to_x(to_x),
        .to_y(to_y),
        .to_z(to_z),
        .x_limit(x_limit_reg),
        .y_limit(y_limit_reg),
        .z_limit(z_limit_reg),
        .pos_x(pos_x),
        .pos_y(pos_y),
        .pos_z(pos_z),
        .moving(moving),
        .shot_taken(shot_taken)
    );

endmodule
`default_nettype wire

@@ hdl/dls3d_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Iterative divider lane
// Restoring division of a delta magnitude scaled by the fraction width by the
// step count, one quotient bit a cycle while run is high, rounded half away from zero.
// ----------------------------------------------------------------------------
module dls3d_div
    import dls3d_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  wire logic                        clk,
    input  wire logic                        load,
    input  wire logic                        run,
    input  wire logic                        first,
    input  wire logic [STEPS_W-1:0]          mag,
    input  wire logic [STEPS_W-1:0]          den,
    input  wire logic                        neg,
    output logic signed [FRAC_BITS+1:0]      quot
);

    logic [STEPS_W:0]     rem_reg;
    logic [STEPS_W:0]     rem_next;
    logic [STEPS_W-1:0]   den_reg;
    logic                 neg_reg;
    logic [FRAC_BITS:0]   quo_reg;
    logic [FRAC_BITS:0]   quo_next;
    logic [STEPS_W:0]     trial;
    logic                 round_up;
    logic [FRAC_BITS:0]   mag_q;

    always_comb
    begin
        trial = first ? rem_reg : {rem_reg[STEPS_W-1:0], 1'b0};
        if (trial >= {1'b0, den_reg})
        begin
            rem_next = trial - {1'b0, den_reg};
            quo_next = {quo_reg[FRAC_BITS-1:0], 1'b1};
        end
        else
        begin
            rem_next = trial;
            quo_next = {quo_reg[FRAC_BITS-1:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rem_reg <= {1'b0, mag};
            den_reg <= den;
            neg_reg <= neg;
            quo_reg <= '0;
        end
        else if (run)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    always_comb
    begin
        round_up = {rem_reg, 1'b0} >= {2'b00, den_reg};
        mag_q    = quo_reg + {{FRAC_BITS{1'b0}}, round_up};
        quot     = neg_reg ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});
    end

endmodule
`default_nettype wire

@@ hdl/dls3d_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// DDA line stepper datapath
// Input latch, position and step registers, bounds test, three divider lanes
// and the result register.
// ----------------------------------------------------------------------------
module dls3d_datapath
    import dls3d_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cmd_t               cmd,
    output sts_t                    sts,
    input  wire logic               func,
    input  wire logic [5:0]         from_x,
    input  wire logic [5:0]         from_y,
    input  wire logic [2:0]         from_z,
    input  wire logic [5:0]         to_x,
    input  wire logic [5:0]         to_y,
    input  wire logic [2:0]         to_z,
    input  wire logic [10:0]        x_limit,
    input  wire logic [10:0]        y_limit,
    input  wire logic [7:0]         z_limit,
    output logic signed [11:0]      pos_x,
    output logic signed [11:0]      pos_y,
    output logic signed [8:0]       pos_z,
    output logic                    moving,
    output logic                    shot_taken
);

    localparam int POS_W  = INT_W + FRAC_BITS;
    localparam int STEP_W = FRAC_BITS + 2;

    logic                       func_reg;
    logic [5:0]                 fx_reg, fy_reg, tx_reg, ty_reg;
    logic [2:0]                 fz_reg, tz_reg;
    logic                       flight_reg;
    logic                       taken_reg;
    logic                       oob_reg;
    logic signed [POS_W-1:0]    px_reg, py_reg, pz_reg;
    logic signed [STEP_W-1:0]   sx_reg, sy_reg, sz_reg;
    logic signed [STEP_W-1:0]   qx, qy, qz;

    logic signed [6:0]          dtx, dty;
    logic signed [3:0]          dtz;
    logic [5:0]                 adx, ady;
    logic [2:0]                 adz;
    logic [STEPS_W-1:0]         mag_x, mag_y, mag_z, steps;
    logic [7:0]                 cz_int;
    logic signed [RND_W-1:0]    rx, ry, rz;
    logic                       oob;

    function automatic logic signed [RND_W-1:0] round_pos(input logic signed [POS_W-1:0] p);
        logic [POS_W-1:0] mag;
        logic [POS_W-1:0] sum;
        logic signed [RND_W-1:0] r;
        mag = p[POS_W-1] ? (~p + POS_W'(1)) : p;
        sum = mag + (POS_W'(1) << (FRAC_BITS - 1));
        r   = $signed({1'b0, sum[POS_W-1:FRAC_BITS]});
        return p[POS_W-1] ? -r : r;
    endfunction

    always_comb
    begin
        dtx   = $signed({1'b0, tx_reg}) - $signed({1'b0, fx_reg});
        dty   = $signed({1'b0, ty_reg}) - $signed({1'b0, fy_reg});
        dtz   = $signed({1'b0, tz_reg}) - $signed({1'b0, fz_reg});
        adx   = dtx[6] ? 6'(-dtx) : dtx[5:0];
        ady   = dty[6] ? 6'(-dty) : dty[5:0];
        adz   = dtz[3] ? 3'(-dtz) : dtz[2:0];
        mag_x = {adx, 4'b0000};
        mag_y = {ady, 4'b0000};
        mag_z = STEPS_W'({adz, 4'b0000}) + STEPS_W'({adz, 3'b000});
        steps = mag_x;
        if (mag_y > steps)
        begin
            steps = mag_y;
        end
        if (mag_z > steps)
        begin
            steps = mag_z;
        end
        cz_int = {1'b0, fz_reg, 4'b0000} + {2'b00, fz_reg, 3'b000} + CELL_Z_HALF;
    end

    always_comb
    begin
        rx  = round_pos(px_reg);
        ry  = round_pos(py_reg);
        rz  = round_pos(pz_reg);
        oob = (rx >= $signed({2'b00, x_limit})) || (rx <= 0)
            || (ry >= $signed({2'b00, y_limit})) || (ry <= 0)
            || (rz >= $signed({5'b00000, z_limit})) || (rz <= 0);
    end

    always_comb
    begin
        sts.is_tick  = (func_reg == FUNC_TICK);
        sts.start_ok = !flight_reg
                     && !(fx_reg == tx_reg && fy_reg == ty_reg && fz_reg == tz_reg);
    end

    dls3d_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
        .clk(clk), .load(cmd.setup), .run(cmd.div_run), .first(cmd.div_first),
        .mag(mag_x), .den(steps), .neg(dtx[6]), .quot(qx)
    );

    dls3d_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
        .clk(clk), .load(cmd.setup), .run(cmd.div_run), .first(cmd.div_first),
        .mag(mag_y), .den(steps), .neg(dty[6]), .quot(qy)
    );

    dls3d_div #(.FRAC_BITS(FRAC_BITS)) u_div_z (
        .clk(clk), .load(cmd.setup), .run(cmd.div_run), .first(cmd.div_first),
        .mag(mag_z), .den(steps), .neg(dtz[3]), .quot(qz)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            func_reg <= func;
            fx_reg   <= from_x;
            fy_reg   <= from_y;
            fz_reg   <= from_z;
            tx_reg   <= to_x;
            ty_reg   <= to_y;
            tz_reg   <= to_z;
        end
        if (cmd.check)
        begin
            oob_reg <= oob;
        end
        if (cmd.emit)
        begin
            pos_x      <= rx[11:0];
            pos_y      <= ry[11:0];
            pos_z      <= rz[8:0];
            moving     <= flight_reg;
            shot_taken <= taken_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flight_reg <= 1'b0;
            taken_reg  <= 1'b0;
            px_reg     <= '0;
            py_reg     <= '0;
            pz_reg     <= '0;
            sx_reg     <= '0;
            sy_reg     <= '0;
            sz_reg     <= '0;
        end
        else
        begin
            if (cmd.latch)
            begin
                taken_reg <= 1'b0;
            end
            if (cmd.setup)
            begin
                taken_reg <= 1'b1;
                px_reg    <= $signed({2'b00, fx_reg, 4'b1000, {FRAC_BITS{1'b0}}});
                py_reg    <= $signed({2'b00, fy_reg, 4'b1000, {FRAC_BITS{1'b0}}});
                pz_reg    <= $signed({4'b0000, cz_int, {FRAC_BITS{1'b0}}});
            end
            if (cmd.store_step)
            begin
                sx_reg     <= qx;
                sy_reg     <= qy;
                sz_reg     <= qz;
                flight_reg <= 1'b1;
            end
            if (cmd.update && flight_reg)
            begin
                if (oob_reg)
                begin
                    flight_reg <= 1'b0;
                end
                else
                begin
                    px_reg <= px_reg + POS_W'(sx_reg);
                    py_reg <= py_reg + POS_W'(sy_reg);
                    pz_reg <= pz_reg + POS_W'(sz_reg);
                end
            end
        end
    end

endmodule
`default_nettype wire

@@ hdl/dls3d_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// DDA line stepper controller
// Sequences accept, setup, division, step store, bounds test, update and result beats.
// ----------------------------------------------------------------------------
module dls3d_ctrl
    import dls3d_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   in_valid,
    output logic        in_stall,
    output logic        out_valid,
    input  wire logic   out_stall,
    input  wire sts_t   sts,
    output cmd_t        cmd
);

    localparam int CNT_W = $clog2(FRAC_BITS + 1);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SETUP  = 7'b0000010,
        S_DIV    = 7'b0000100,
        S_STEP   = 7'b0001000,
        S_CHECK  = 7'b0010000,
        S_UPDATE = 7'b0100000,
        S_EMIT   = 7'b1000000
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                cnt_next = '0;
                if (sts.is_tick)
                begin
                    state_next = S_CHECK;
                end
                else if (sts.start_ok)
                begin
                    cmd.setup  = 1'b1;
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_DIV:
            begin
                cmd.div_run   = 1'b1;
                cmd.div_first = (cnt_reg == '0);
                cnt_next      = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(FRAC_BITS))
                begin
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                cmd.store_step = 1'b1;
                state_next     = S_EMIT;
            end
            S_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef ASSERT_OFF
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !(out_valid_reg && out_stall))
        else $error("Result loaded while a stalled beat is pending.");

    a_accept_setup: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == S_SETUP))
        else $error("Accepted beat not followed by setup.");

    a_step_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_STEP) |-> ($past(state_reg) == S_DIV))
        else $error("Step store without a finished division.");

    a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_EMIT))
        else $error("Output valid raised outside the result state.");
`endif

endmodule
`default_nettype wire

@@ sim/dda_line_stepper_3d_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// 3D DDA line stepper testbench
// A queue-fed driver sends start and tick beats with random gaps, and a
// clocked monitor takes results under random stall and one long hold-off.
// An internal shadow of the projectile predicts each result, and results are
// checked in order. The limits are read back after every write and are swept
// from zero to full scale between phases.
// ----------------------------------------------------------------------------
module dda_line_stepper_3d_tb;
    import dls3d_pkg::*;

    localparam int FRAC        = 16;
    localparam int POS_W       = INT_W + FRAC;
    localparam int STEP_W      = 2 + FRAC;
    localparam int RX_HOLD     = 400;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic       func;
        logic [5:0] from_x;
        logic [5:0] from_y;
        logic [2:0] from_z;
        logic [5:0] to_x;
        logic [5:0] to_y;
        logic [2:0] to_z;
    } shot_cmd_t;

    typedef struct packed {
        logic signed [11:0] pos_x;
        logic signed [11:0] pos_y;
        logic signed [8:0]  pos_z;
        logic               moving;
        logic               shot_taken;
    } track_sample_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    shot_cmd_t   tx_cmd = '0;
    logic        out_stall = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;

    logic               in_stall;
    logic               out_valid;
    logic signed [11:0] pos_x;
    logic signed [11:0] pos_y;
    logic signed [8:0]  pos_z;
    logic               moving;
    logic               shot_taken;
    logic [31:0]        prdata;
    logic               pready;

    logic signed [POS_W-1:0]  proj_px, proj_py, proj_pz;
    logic signed [STEP_W-1:0] proj_sx, proj_sy, proj_sz;
    logic                     flying;
    logic [10:0]              lim_x, lim_y;
    logic [7:0]               lim_z;

    shot_cmd_t     shot_cmds[$];
    track_sample_t expected_track[$];
    track_sample_t rx_got, rx_want;

    int  queued = 0;
    int  beats_in = 0;
    int  results_seen = 0;
    int  shots_launched = 0;
    int  flights_ended = 0;
    int  mismatches = 0;
    int  settings = 0;
    int  cycles = 0;
    int  tx_gap;
    int  rx_wait;
    int  rx_hold_left;
    int  rx_hold_reqs = 0;
    int  rx_hold_done = 0;
    logic steady = 1'b0;
    logic was_moving = 1'b0;

    dda_line_stepper_3d #(.FRAC_BITS(FRAC)) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .func       (tx_cmd.func),
        .from_x     (tx_cmd.from_x),
        .from_y     (tx_cmd.from_y),
        .from_z     (tx_cmd.from_z),
        .to_x       (tx_cmd.to_x),
        .to_y       (tx_cmd.to_y),
        .to_z       (tx_cmd.to_z),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .pos_z      (pos_z),
        .moving     (moving),
        .shot_taken (shot_taken),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int round_half_away(input logic signed [POS_W-1:0] p);
        longint v, mag;
        v = p;
        mag = (v < 0) ? -v : v;
        mag = (mag + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
        return (v < 0) ? int'(-mag) : int'(mag);
    endfunction

    function automatic logic signed [STEP_W-1:0] step_for(input int delta, input int span);
        longint mag, q;
        mag = (delta < 0) ? -delta : delta;
        q = ((mag <<< FRAC) * 2 + span) / (longint'(span) * 2);
        return (delta < 0) ? STEP_W'(-q) : STEP_W'(q);
    endfunction

    function automatic logic leaves_bounds(input logic signed [POS_W-1:0] p, input int limit);
        int r;
        r = round_half_away(p);
        return (r >= limit) || (r <= 0);
    endfunction

    function automatic int iabs(input int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic track_sample_t advance_projectile(input shot_cmd_t c);
        track_sample_t s;
        int sx, sy, sz, dx, dy, dz, span;
        logic taken;
        taken = 1'b0;
        if (c.func == FUNC_START) begin
            if (!flying && !(c.from_x == c.to_x && c.from_y == c.to_y && c.from_z == c.to_z))
            begin
                sx = int'(c.from_x) * 16 + 8;
                sy = int'(c.from_y) * 16 + 8;
                sz = int'(c.from_z) * 24 + 12;
                dx = int'(c.to_x) * 16 + 8 - sx;
                dy = int'(c.to_y) * 16 + 8 - sy;
                dz = int'(c.to_z) * 24 + 12 - sz;
                span = iabs(dx);
                if (iabs(dy) > span)
                    span = iabs(dy);
                if (iabs(dz) > span)
                    span = iabs(dz);
                proj_px = POS_W'(sx * (1 << FRAC));
                proj_py = POS_W'(sy * (1 << FRAC));
                proj_pz = POS_W'(sz * (1 << FRAC));
                proj_sx = step_for(dx, span);
                proj_sy = step_for(dy, span);
                proj_sz = step_for(dz, span);
                flying = 1'b1;
                taken = 1'b1;
            end
        end else if (flying) begin
            if (leaves_bounds(proj_px, int'(lim_x)) || leaves_bounds(proj_py, int'(lim_y)) ||
                leaves_bounds(proj_pz, int'(lim_z)))
            begin
                flying = 1'b0;
            end else begin
                proj_px = proj_px + proj_sx;
                proj_py = proj_py + proj_sy;
                proj_pz = proj_pz + proj_sz;
            end
        end
        s.pos_x = 12'(round_half_away(proj_px));
        s.pos_y = 12'(round_half_away(proj_py));
        s.pos_z = 9'(round_half_away(proj_pz));
        s.moving = flying;
        s.shot_taken = taken;
        return s;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(12, 40);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            tx_gap <= 0;
        end else begin
            if (in_valid && !in_stall) begin
                expected_track.push_back(advance_projectile(tx_cmd));
                beats_in++;
            end
            if (!in_valid || !in_stall) begin
                if (tx_gap > 0) begin
                    in_valid <= 1'b0;
                    tx_gap <= tx_gap - 1;
                end else if (shot_cmds.size() > 0) begin
                    tx_cmd <= shot_cmds.pop_front();
                    in_valid <= 1'b1;
                    tx_gap <= steady ? 0 : pick_gap();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_stall <= 1'b0;
            rx_wait <= 0;
            rx_hold_left <= 0;
        end else begin
            if (out_valid && !out_stall) begin
                rx_got = '{pos_x, pos_y, pos_z, moving, shot_taken};
                results_seen++;
                if (expected_track.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: x=%0d y=%0d z=%0d moving=%0b shot=%0b",
                                 rx_got.pos_x, rx_got.pos_y, rx_got.pos_z, rx_got.moving,
                                 rx_got.shot_taken);
                end else begin
                    rx_want = expected_track.pop_front();
                    if (rx_got.pos_x !== rx_want.pos_x || rx_got.pos_y !== rx_want.pos_y ||
                        rx_got.pos_z !== rx_want.pos_z || rx_got.moving !== rx_want.moving ||
                        rx_got.shot_taken !== rx_want.shot_taken)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result %0d: expected x=%0d y=%0d z=%0d m=%0b s=%0b, got x=%0d y=%0d z=%0d m=%0b s=%0b",
                                     results_seen, rx_want.pos_x, rx_want.pos_y,
                                     rx_want.pos_z, rx_want.moving, rx_want.shot_taken,
                                     rx_got.pos_x, rx_got.pos_y, rx_got.pos_z,
                                     rx_got.moving, rx_got.shot_taken);
                    end
                    if (rx_want.shot_taken)
                        shots_launched++;
                    if (was_moving && !rx_want.moving)
                        flights_ended++;
                    was_moving = rx_want.moving;
                end
            end
            if (rx_hold_left > 0) begin
                out_stall <= 1'b1;
                rx_hold_left <= rx_hold_left - 1;
            end else if (rx_hold_done != rx_hold_reqs) begin
                out_stall <= 1'b1;
                rx_hold_left <= RX_HOLD;
                rx_hold_done <= rx_hold_done + 1;
            end else if (rx_wait > 0) begin
                out_stall <= 1'b1;
                rx_wait <= rx_wait - 1;
            end else begin
                out_stall <= 1'b0;
                if (!steady && $urandom_range(0, 2) == 0)
                    rx_wait <= pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic check_limit(input logic [1:0] idx);
        logic [31:0] got, want;
        case (idx)
            REG_X_LIMIT: want = {21'd0, lim_x};
            REG_Y_LIMIT: want = {21'd0, lim_y};
            default:     want = {24'd0, lim_z};
        endcase
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        got = prdata;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("limit register %0d: expected %0d, read %0d", idx, want, got);
        end
    endtask

    task automatic write_limit(input logic [1:0] idx, input logic [10:0] value);
        logic [31:0] word;
        word = $urandom;
        word[10:0] = value;
        if ($urandom_range(0, 1) == 0)
            word[31:11] = '0;
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= word;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_X_LIMIT: lim_x = word[10:0];
            REG_Y_LIMIT: lim_y = word[10:0];
            default:     lim_z = word[7:0];
        endcase
        check_limit(idx);
    endtask

    task automatic set_limits(input logic [10:0] x, input logic [10:0] y, input logic [7:0] z);
        write_limit(REG_X_LIMIT, x);
        write_limit(REG_Y_LIMIT, y);
        write_limit(REG_Z_LIMIT, {3'd0, z});
        settings++;
    endtask

    task automatic wait_drained();
        while (shot_cmds.size() != 0 || in_valid || expected_track.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    function automatic shot_cmd_t random_fields();
        logic [30:0] raw;
        shot_cmd_t c;
        raw = 31'($urandom);
        c = raw;
        return c;
    endfunction

    task automatic queue_cmd(input shot_cmd_t c);
        shot_cmds.push_back(c);
        queued++;
    endtask

    task automatic queue_tick();
        shot_cmd_t c;
        c = random_fields();
        c.func = FUNC_TICK;
        queue_cmd(c);
    endtask

    task automatic queue_start(input logic [5:0] fx, input logic [5:0] fy, input logic [2:0] fz,
                               input logic [5:0] tx, input logic [5:0] ty, input logic [2:0] tz);
        queue_cmd('{FUNC_START, fx, fy, fz, tx, ty, tz});
    endtask

    task automatic queue_random_start();
        shot_cmd_t c;
        c = random_fields();
        c.func = FUNC_START;
        if (c.from_x == c.to_x && c.from_y == c.to_y && c.from_z == c.to_z)
            c.to_x = c.to_x ^ 6'd1;
        queue_cmd(c);
    endtask

    task automatic queue_equal_start();
        shot_cmd_t c;
        c = random_fields();
        c.func = FUNC_START;
        c.to_x = c.from_x;
        c.to_y = c.from_y;
        c.to_z = c.from_z;
        queue_cmd(c);
    endtask

    task automatic random_phase(input int budget, input int max_ticks);
        int stop_at, k, r;
        stop_at = queued + budget;
        while (queued < stop_at) begin
            r = $urandom_range(0, 99);
            if (r < 78) begin
                queue_random_start();
                k = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4)
                                                 : $urandom_range(1, max_ticks);
                repeat (k) begin
                    if (queued >= stop_at)
                        break;
                    if ($urandom_range(0, 29) == 0)
                        queue_random_start();
                    else
                        queue_tick();
                end
            end else if (r < 86) begin
                queue_equal_start();
            end else begin
                queue_cmd(random_fields());
            end
        end
    endtask

    initial
    begin
        lim_x = X_LIMIT_RST;
        lim_y = Y_LIMIT_RST;
        lim_z = Z_LIMIT_RST;
        proj_px = '0;
        proj_py = '0;
        proj_pz = '0;
        proj_sx = '0;
        proj_sy = '0;
        proj_sz = '0;
        flying = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        check_limit(REG_X_LIMIT);
        check_limit(REG_Y_LIMIT);
        check_limit(REG_Z_LIMIT);

        queue_tick();
        queue_start(6'd63, 6'd63, 3'd7, 6'd63, 6'd63, 3'd7);
        queue_start(6'd0, 6'd0, 3'd0, 6'd0, 6'd0, 3'd0);
        queue_start(6'd0, 6'd0, 3'd0, 6'd63, 6'd63, 3'd7);
        queue_start(6'd5, 6'd5, 3'd5, 6'd6, 6'd6, 3'd6);
        repeat (3) queue_tick();
        wait_drained();

        set_limits(11'd1, 11'd1, 8'd1);
        queue_tick();
        queue_tick();
        queue_start(6'd63, 6'd63, 3'd7, 6'd0, 6'd0, 3'd0);
        queue_tick();
        wait_drained();

        set_limits(11'd0, 11'd0, 8'd0);
        queue_start(6'd10, 6'd20, 3'd3, 6'd10, 6'd20, 3'd4);
        queue_tick();
        wait_drained();

        set_limits(11'd2047, 11'd2047, 8'd255);
        queue_start(6'd1, 6'd30, 3'd3, 6'd0, 6'd30, 3'd3);
        repeat (5) queue_tick();
        queue_start(6'd0, 6'd0, 3'd0, 6'd0, 6'd63, 3'd0);
        wait_drained();

        repeat (22) queue_tick();
        queue_start(6'd62, 6'd40, 3'd5, 6'd63, 6'd40, 3'd5);
        repeat (40) queue_tick();
        random_phase(200, 60);
        wait_drained();

        set_limits(X_LIMIT_RST, Y_LIMIT_RST, Z_LIMIT_RST);
        rx_hold_reqs <= rx_hold_reqs + 1;
        random_phase(250, 200);
        wait_drained();

        for (int i = 0; i < 6; i++) begin
            set_limits(($urandom_range(0, 4) == 0) ? 11'($urandom_range(0, 2047))
                                                    : 11'($urandom_range(16, 300)),
                       ($urandom_range(0, 4) == 0) ? 11'($urandom_range(0, 2047))
                                                    : 11'($urandom_range(16, 300)),
                       8'($urandom_range(16, 255)));
            steady <= (i == 3);
            random_phase(150, 120);
            wait_drained();
        end
        steady <= 1'b0;
        repeat (20) @(negedge clk);

        $display("summary: %0d beats in, %0d results checked, %0d shots launched, %0d flights ended",
                 beats_in, results_seen, shots_launched, flights_ended);
        $display("summary: %0d limit settings from zero to full scale, %0d mismatches",
                 settings, mismatches);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ dda_line_stepper_3d.f @@
hdl/dls3d_pkg.sv
hdl/dls3d_div.sv
hdl/dls3d_datapath.sv
hdl/dls3d_ctrl.sv
hdl/dda_line_stepper_3d.sv
sim/dda_line_stepper_3d_tb.sv
